@@ src/fcirc_pkg.sv @@
package fcirc_pkg;

  // Operation codes carried on the request channel
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Per-cycle control for every cell of the tap row
  typedef struct packed {
    logic shift;   // take the sample of the upstream neighbor
    logic rotate;  // take sample and coefficient of the downstream neighbor
  } cell_ctrl_t;

  // Control for the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;   // preload accumulator with the rounding constant
    logic mul;     // multiply the pair at the head of the row
  } mac_ctrl_t;

endpackage

@@ src/fcirc_req_if.sv @@
interface fcirc_req_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic        [4:0]             coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;

  modport source (output valid, operation, sample, coef_index, coef_value, input ready);
  modport sink   (input valid, operation, sample, coef_index, coef_value, output ready);
endinterface

@@ src/fcirc_res_if.sv @@
interface fcirc_res_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_sample;
  logic                          saturated;

  modport source (output valid, filtered_sample, saturated, input ready);
  modport sink   (input valid, filtered_sample, saturated, output ready);
endinterface

@@ src/fcirc_cell.sv @@
module fcirc_cell
  import fcirc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cell_ctrl_t                    ctrl,
  input  logic                          load,
  input  logic signed [COEF_BITS-1:0]   load_value,
  input  logic signed [SAMPLE_BITS-1:0] prev_sample,
  input  logic signed [SAMPLE_BITS-1:0] next_sample,
  input  logic signed [COEF_BITS-1:0]   next_coef,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [COEF_BITS-1:0]   coef
);

  // History slot: shifts on a new sample, rotates during accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (ctrl.shift) begin
      sample <= prev_sample;
    end else if (ctrl.rotate) begin
      sample <= next_sample;
    end
  end

  // Coefficient slot: loaded by address match, rotates with the sample
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (load) begin
      coef <= load_value;
    end else if (ctrl.rotate) begin
      coef <= next_coef;
    end
  end

endmodule

@@ src/fcirc_mac.sv @@
module fcirc_mac
  import fcirc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16,
  parameter int TAPS        = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [COEF_BITS-1:0]   coef,
  output logic signed [SAMPLE_BITS-1:0] result,
  output logic                          saturated
);

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
  localparam int Y_W    = ACC_W - COEF_BITS + 1;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_BITS - 2);
  localparam logic signed [SAMPLE_BITS-1:0] MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;
  logic signed [Y_W-1:0]    y_full;
  logic                     fits;

  // Product stage
  always_ff @(posedge clk) begin
    prod <= sample * coef;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.mul;
    end
  end

  // Accumulator, preloaded with the half-LSB rounding term
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= RND;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Scale back to sample format and clip
  assign y_full = Y_W'(acc >>> (COEF_BITS - 1));
  assign fits   = (&y_full[Y_W-1:SAMPLE_BITS-1]) | ~(|y_full[Y_W-1:SAMPLE_BITS-1]);

  always_comb begin
    saturated = ~fits;
    if (fits) begin
      result = y_full[SAMPLE_BITS-1:0];
    end else if (y_full[Y_W-1]) begin
      result = MINV;
    end else begin
      result = MAXV;
    end
  end

endmodule

@@ src/fir_filter_circular.sv @@
// Load request: taken while idle, no result.
// Filter request: taken only in idle; the single shared multiply-accumulate unit
// walks the tap row one tap per cycle in run, then drain; finish registers the
// result once the output slot is free. A new request is taken while a result waits.
// Synchronous active-high reset clears history and coefficients to zero.
module fir_filter_circular
  import fcirc_pkg::*;
#(
  parameter int TAPS        = 32,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input logic         clk,
  input logic         rst,
  fcirc_req_if.sink   request,
  fcirc_res_if.source result
);

  localparam int CNT_W = $clog2(TAPS);

  state_t     state, state_next;
  logic [CNT_W-1:0] cnt;
  logic       accept;
  logic       is_filter;
  logic       last_tap;
  logic       slot_free;
  logic       finish;
  cell_ctrl_t cell_ctrl;
  mac_ctrl_t  mac_ctrl;

  logic signed [SAMPLE_BITS-1:0] samp [TAPS];
  logic signed [COEF_BITS-1:0]   coefs [TAPS];
  logic signed [SAMPLE_BITS-1:0] mac_result;
  logic                          mac_sat;

  logic                          res_valid;
  logic signed [SAMPLE_BITS-1:0] res_sample;
  logic                          res_sat;

  assign accept    = request.valid && request.ready;
  assign is_filter = (request.operation == OP_FILTER);
  assign last_tap  = (cnt == CNT_W'(TAPS - 1));
  assign slot_free = !res_valid || result.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept && is_filter) state_next = ST_RUN;
      ST_RUN:    if (last_tap) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer; ready is high throughout idle
  always_comb begin
    request.ready    = 1'b0;
    cell_ctrl.shift  = 1'b0;
    cell_ctrl.rotate = 1'b0;
    mac_ctrl.clear   = 1'b0;
    mac_ctrl.mul     = 1'b0;
    finish           = 1'b0;
    case (state)
      ST_IDLE: begin
        request.ready   = 1'b1;
        cell_ctrl.shift = request.valid && is_filter;
        mac_ctrl.clear  = request.valid && is_filter;
      end
      ST_RUN: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.mul     = 1'b1;
      end
      ST_DRAIN: ;
      ST_FINISH: finish = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_RUN) begin
      cnt <= last_tap ? '0 : cnt + 1'b1;
    end
  end

  // Row of tap cells; cell 0 holds the newest sample and feeds the MAC
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    localparam int NXT = (k + 1) % TAPS;
    logic                          load;
    logic signed [SAMPLE_BITS-1:0] prev_sample;

    assign load = accept && !is_filter && (32'(request.coef_index) == k);
    if (k == 0) begin : g_head
      assign prev_sample = request.sample;
    end else begin : g_body
      assign prev_sample = samp[k-1];
    end

    fcirc_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEF_BITS  (COEF_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .load       (load),
      .load_value (request.coef_value),
      .prev_sample(prev_sample),
      .next_sample(samp[NXT]),
      .next_coef  (coefs[NXT]),
      .sample     (samp[k]),
      .coef       (coefs[k])
    );
  end

  fcirc_mac #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS),
    .TAPS       (TAPS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctrl),
    .sample   (samp[0]),
    .coef     (coefs[0]),
    .result   (mac_result),
    .saturated(mac_sat)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res_sample <= mac_result;
      res_sat    <= mac_sat;
    end
  end

  assign result.valid           = res_valid;
  assign result.filtered_sample = res_sample;
  assign result.saturated       = res_sat;

endmodule
